>>> hdl/mca_pkg.sv
// Package for the MIDI channel allocator: widths, command codes, register
// indexes, sequencer states and the result record.
// No dependencies; used by the top level midi_channel_allocator.
package mca_pkg;

    localparam int CHANNELS  = 16;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int OWNER_W   = 8;
    localparam int GRANT_W   = 5;
    localparam int CMD_W     = 24;

    localparam logic [GRANT_W-1:0] NO_MAP = 5'h1F;

    localparam logic [CMD_W-1:0] CMD_PITCH_RESET = 24'h4000E0;
    localparam logic [CMD_W-1:0] CMD_PEDAL_OFF   = 24'h0040B0;
    localparam logic [CMD_W-1:0] CMD_DRIVER_OFF  = 24'h004BB0;

    // Highest channel the fallback scan and the release sweep visit.
    localparam logic [CH_W-1:0] SCAN_LAST = 4'd14;
    // First value past the scan range; a start channel here finds nothing.
    localparam logic [CH_W-1:0] SCAN_END  = 4'd15;
    localparam logic [CH_W-1:0] PERC_CH   = 4'd9;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_LEGACY = 1'b0;
    localparam logic REG_FIRST  = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Order of the commands sent per released channel; EMIT_DRV is the previous channel's.
    typedef enum logic [1:0] {
        EMIT_DRV   = 2'd0,
        EMIT_PITCH = 2'd1,
        EMIT_PEDAL = 2'd2
    } emit_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic [GRANT_W-1:0] grant;
        logic               cmd_vld;
        logic [CMD_W-1:0]   cmd;
        logic               last;
    } result_t;

endpackage

>>> hdl/midi_channel_allocator.sv
// Top level of the MIDI channel allocator: sequencer, configuration port,
// output register and the two table memories.
// Depends on mca_pkg and mca_ram.
//
//   Channel   Direction  Handshake          Content
//   s_        in         s_tvalid/s_tready  tuser = mode, tdata = owner, channel
//   m_        out        m_tvalid/m_tready  tdata = grant, command; tlast = last
//   APB       in/out     psel/penable       legacy_bypass, first_channel
//
// One transaction is worked on at a time; every table lookup passes ST_RD and ST_CHK
// (address, then registered read data). A bypass allocate goes straight to ST_DONE;
// else the preferred channel is checked, then the fallback scan if it is taken. A free
// sweeps channels 0..14, sending pitch reset and pedal off per released channel with a
// valid remap and its driver off later, the last one on the final result. Reset is
// synchronous and clears one valid bit per entry, so the tables come up empty at once.
// A stalled m_tready holds the sequencer in ST_EMIT and ST_DONE.
module midi_channel_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] owner_id, [11:8] best_channel, [15:12] zero
    input  logic        s_tuser,    // [0] mode
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [4:0] granted_channel, [5] command_valid,
                                    // [29:6] midi_command, [31:30] zero
    output logic        m_tlast     // last
);

    localparam int CH_W    = mca_pkg::CH_W;
    localparam int OWNER_W = mca_pkg::OWNER_W;

    // Configuration registers. User writes only while the block is idle; not enforced.
    logic            legacy_reg;
    logic [CH_W-1:0] first_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            legacy_reg <= 1'b0;
            first_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                mca_pkg::REG_LEGACY: legacy_reg <= pwdata[0];
                mca_pkg::REG_FIRST:  first_reg  <= pwdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mca_pkg::REG_LEGACY: prdata = {31'd0, legacy_reg};
            mca_pkg::REG_FIRST:  prdata = {28'd0, first_reg};
            default:             prdata = '0;
        endcase
    end

    // Sequencer registers.
    mca_pkg::state_t         state_reg,    state_next;
    logic                    mode_reg,     mode_next;
    logic [OWNER_W-1:0]      owner_reg,    owner_next;
    logic [CH_W-1:0]         best_reg,     best_next;
    logic [CH_W-1:0]         idx_reg,      idx_next;
    logic                    scan_reg,     scan_next;
    mca_pkg::emit_t          cnt_reg,      cnt_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [CH_W-1:0]         pend_ch_reg,  pend_ch_next;
    logic [CH_W-1:0]         rmp_ch_reg,   rmp_ch_next;
    logic [mca_pkg::GRANT_W-1:0] grant_reg, grant_next;

    // Per-entry valid bits; an entry without one reads as its reset value.
    logic [mca_pkg::CHANNELS-1:0] own_vld_reg;
    logic [mca_pkg::CHANNELS-1:0] rmp_vld_reg;
    logic                         own_vq_reg;
    logic                         rmp_vq_reg;

    logic [OWNER_W-1:0] own_rdata;
    logic [CH_W-1:0]    rmp_rdata;
    logic [OWNER_W-1:0] own_q;
    logic               own_we;
    logic               rmp_we;
    logic               ent_clr;
    logic               scan_done;

    // Output register.
    logic             m_tvalid_reg;
    mca_pkg::result_t out_reg;
    mca_pkg::result_t out_res;
    logic             out_load;
    logic             out_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign own_q     = own_vq_reg ? own_rdata : '0;
    assign scan_done = (idx_reg == mca_pkg::SCAN_LAST);
    assign s_tready  = (state_reg == mca_pkg::ST_IDLE);

    // Owner table: written at the entry under test, read at the scan index.
    mca_ram #(.WIDTH(OWNER_W), .DEPTH(mca_pkg::CHANNELS)) u_owner_ram (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (idx_reg),
        .wdata (owner_reg),
        .raddr (idx_reg),
        .rdata (own_rdata)
    );

    // Remap table: always written at the preferred channel's entry, even when
    // the fallback scan granted a different channel.
    mca_ram #(.WIDTH(CH_W), .DEPTH(mca_pkg::CHANNELS)) u_remap_ram (
        .aclk  (aclk),
        .we    (rmp_we),
        .waddr (best_reg),
        .wdata (idx_reg),
        .raddr (idx_reg),
        .rdata (rmp_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        owner_next    = owner_reg;
        best_next     = best_reg;
        idx_next      = idx_reg;
        scan_next     = scan_reg;
        cnt_next      = cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_ch_next  = pend_ch_reg;
        rmp_ch_next   = rmp_ch_reg;
        grant_next    = grant_reg;
        own_we        = 1'b0;
        rmp_we        = 1'b0;
        ent_clr       = 1'b0;
        out_load      = 1'b0;
        out_res       = '{grant: mca_pkg::NO_MAP, cmd_vld: 1'b0, cmd: '0, last: 1'b0};

        case (state_reg)
            mca_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next     = s_tuser;
                    owner_next    = s_tdata[7:0];
                    best_next     = s_tdata[11:8];
                    idx_next      = s_tdata[11:8];
                    scan_next     = 1'b0;
                    pend_vld_next = 1'b0;
                    if (s_tuser == mca_pkg::MODE_FREE) begin
                        idx_next   = '0;
                        state_next = mca_pkg::ST_RD;
                    end else if (legacy_reg) begin
                        grant_next = {1'b0, s_tdata[11:8]};
                        state_next = mca_pkg::ST_DONE;
                    end else begin
                        state_next = mca_pkg::ST_RD;
                    end
                end
            end

            mca_pkg::ST_RD: begin
                state_next = mca_pkg::ST_CHK;
            end

            mca_pkg::ST_CHK: begin
                if (mode_reg == mca_pkg::MODE_ALLOC) begin
                    if (own_q == '0 && (!scan_reg || idx_reg != mca_pkg::PERC_CH)) begin
                        own_we     = 1'b1;
                        rmp_we     = 1'b1;
                        grant_next = {1'b0, idx_reg};
                        state_next = mca_pkg::ST_DONE;
                    end else if (!scan_reg) begin
                        if (first_reg == mca_pkg::SCAN_END) begin
                            grant_next = mca_pkg::NO_MAP;
                            state_next = mca_pkg::ST_DONE;
                        end else begin
                            idx_next   = first_reg;
                            scan_next  = 1'b1;
                            state_next = mca_pkg::ST_RD;
                        end
                    end else if (scan_done) begin
                        grant_next = mca_pkg::NO_MAP;
                        state_next = mca_pkg::ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = mca_pkg::ST_RD;
                    end
                end else begin
                    if (own_q == owner_reg) begin
                        ent_clr = 1'b1;
                    end
                    if (own_q == owner_reg && rmp_vq_reg) begin
                        rmp_ch_next = rmp_rdata;
                        cnt_next    = pend_vld_reg ? mca_pkg::EMIT_DRV : mca_pkg::EMIT_PITCH;
                        state_next  = mca_pkg::ST_EMIT;
                    end else if (scan_done) begin
                        state_next = mca_pkg::ST_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = mca_pkg::ST_RD;
                    end
                end
            end

            mca_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_res.cmd_vld = 1'b1;
                    case (cnt_reg)
                        mca_pkg::EMIT_DRV:
                            out_res.cmd = mca_pkg::CMD_DRIVER_OFF | {20'd0, pend_ch_reg};
                        mca_pkg::EMIT_PITCH:
                            out_res.cmd = mca_pkg::CMD_PITCH_RESET | {20'd0, rmp_ch_reg};
                        default:
                            out_res.cmd = mca_pkg::CMD_PEDAL_OFF | {20'd0, rmp_ch_reg};
                    endcase
                    if (cnt_reg == mca_pkg::EMIT_PEDAL) begin
                        // The driver release is held back until it is known
                        // whether it is the final result of this free.
                        pend_vld_next = 1'b1;
                        pend_ch_next  = rmp_ch_reg;
                        if (scan_done) begin
                            state_next = mca_pkg::ST_DONE;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = mca_pkg::ST_RD;
                        end
                    end else begin
                        cnt_next = (cnt_reg == mca_pkg::EMIT_DRV) ? mca_pkg::EMIT_PITCH
                                                                  : mca_pkg::EMIT_PEDAL;
                    end
                end
            end

            mca_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_res.last = 1'b1;
                    if (mode_reg == mca_pkg::MODE_FREE) begin
                        if (pend_vld_reg) begin
                            out_res.cmd_vld = 1'b1;
                            out_res.cmd = mca_pkg::CMD_DRIVER_OFF | {20'd0, pend_ch_reg};
                        end
                    end else begin
                        out_res.grant = grant_reg;
                    end
                    state_next = mca_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mca_pkg::ST_IDLE;
            own_vld_reg  <= '0;
            rmp_vld_reg  <= '0;
            own_vq_reg   <= 1'b0;
            rmp_vq_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            // Valid bits are sampled with the same address as the RAM read.
            own_vq_reg   <= own_vld_reg[idx_reg];
            rmp_vq_reg   <= rmp_vld_reg[idx_reg];
            if (own_we) begin
                own_vld_reg[idx_reg] <= 1'b1;
            end
            if (rmp_we) begin
                rmp_vld_reg[best_reg] <= 1'b1;
            end
            // Releasing an entry returns both tables to their reset values.
            if (ent_clr) begin
                own_vld_reg[idx_reg] <= 1'b0;
                rmp_vld_reg[idx_reg] <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        owner_reg   <= owner_next;
        best_reg    <= best_next;
        idx_reg     <= idx_next;
        scan_reg    <= scan_next;
        cnt_reg     <= cnt_next;
        pend_ch_reg <= pend_ch_next;
        rmp_ch_reg  <= rmp_ch_next;
        grant_reg   <= grant_next;
        if (out_load) begin
            out_reg <= out_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.cmd, out_reg.cmd_vld, out_reg.grant};
    assign m_tlast  = out_reg.last;

endmodule

>>> hdl/mca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mca_checker.sv
// Port-level checker for the MIDI channel allocator, bound to the top level.
// Depends on midi_channel_allocator only through the bind below.
module mca_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // One request at a time: after a transaction the input closes.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request was in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A command only comes out of a free, whose results carry no channel.
    a_cmd_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4:0] == 5'h1F)
        else $error("command result carries a granted channel");

    a_idle_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[5] |-> m_tdata[29:6] == 24'd0 && m_tlast)
        else $error("result without command is not a final, empty result");

endmodule

bind midi_channel_allocator mca_checker u_mca_checker (.*);
